[sv/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// shared widths, limits and the command/status bundles between the
// controller and the datapath of the lfu page replacement block
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int PAGE_ID_W = 16;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = 16;
  localparam int STAMP_W   = 32;

  localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [STAMP_W-1:0] STAMP_MAX    = {STAMP_W{1'b1}};
  localparam logic [CFG_W-1:0]   ACTIVE_RESET = 5'd16;

  // commands from the controller
  typedef struct packed {
    logic load;    // capture the referenced page, clear search flags
    logic scan;    // read the slot at the scan index, advance it
    logic commit;  // write the chosen slot, load the result register
  } dp_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic last_issue;  // scan index is at the last active slot
    logic out_free;    // result register can take a new result
  } dp_stat_t;

endpackage

[sv/lfu_page_replacement.sv]
// ----------------------------------------------------------------------------
// lfu_page_replacement
// fully associative page slot table, least frequently used replacement with
// oldest stamp then lowest slot as tie breaks
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_page_id
//  out      output     out_valid / out_stall  out_hit, out_slot, out_evicted,
//                                             out_evicted_page
//  cfg      input      cfg_wr_en              cfg_active_entries
//
//  a reference is taken in, then each of the n active slots (1..ENTRIES)
//  is read in turn through the single read port of the slot ram, the last
//  read word is compared, and the chosen slot is written back
//  reset is synchronous, active low; clears valid bits, time and handshakes
//  a result waits in the output register; a stalled output holds only the
//  commit of the next reference, whose scan may already run
//
module lfu_page_replacement #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]          cfg_active_entries,
  // reference input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lfu_pkg::PAGE_ID_W-1:0]      in_page_id,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted,
  output logic [lfu_pkg::PAGE_ID_W-1:0]      out_evicted_page
);

  // controller to datapath commands, datapath status back
  lfu_pkg::dp_cmd_t  cmd;
  lfu_pkg::dp_stat_t stat;

  // sequencer: idle -> scan active slots -> drain last read -> commit
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot ram, serial search, update and result register
  lfu_dpath #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_active_entries (cfg_active_entries),
    .in_page_id         (in_page_id),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_slot           (out_slot),
    .out_evicted        (out_evicted),
    .out_evicted_page   (out_evicted_page)
  );

endmodule

[sv/lfu_ram.sv]
// ----------------------------------------------------------------------------
// lfu_ram
// generic single port ram, one write or one read per cycle, registered read
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

[sv/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer for one reference: accept, scan the active slots, commit
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lfu_pkg::dp_stat_t stat,
  output lfu_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is compared here
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_drain_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_COMMIT))
    else $error("drain not followed by commit");
`endif

endmodule

[sv/lfu_dpath.sv]
// ----------------------------------------------------------------------------
// lfu_dpath
// slot store, serial match and victim search, slot update, result register
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]          cfg_active_entries,
  input  logic [lfu_pkg::PAGE_ID_W-1:0]      in_page_id,
  input  lfu_pkg::dp_cmd_t                   cmd,
  output lfu_pkg::dp_stat_t                  stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted,
  output logic [lfu_pkg::PAGE_ID_W-1:0]      out_evicted_page
);

  localparam int PW    = (PAGE_BITS < lfu_pkg::PAGE_ID_W) ? PAGE_BITS : lfu_pkg::PAGE_ID_W;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = lfu_pkg::CNT_W;
  localparam int TW    = lfu_pkg::STAMP_W;
  localparam int RW    = PW + CW + TW;

  // configuration and active slot range
  logic [lfu_pkg::CFG_W-1:0] cfg_active_r;
  logic [lfu_pkg::CFG_W-1:0] eff_n;
  logic [IDX_W-1:0]          last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= lfu_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      cfg_active_r <= cfg_active_entries;
    end
  end

  always_comb begin
    if (cfg_active_r == '0) begin
      eff_n = lfu_pkg::CFG_W'(1);
    end else if (32'(cfg_active_r) > ENTRIES) begin
      eff_n = lfu_pkg::CFG_W'(ENTRIES);
    end else begin
      eff_n = cfg_active_r;
    end
  end

  assign last_idx = IDX_W'(eff_n - lfu_pkg::CFG_W'(1));

  // request and scan state
  logic [PW-1:0]    page_r;
  logic [IDX_W-1:0] idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] found_r;
  logic [CW-1:0]    hit_cnt_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             best_vld_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [CW-1:0]    best_cnt_r;
  logic [TW-1:0]    best_stamp_r;
  logic [PW-1:0]    best_page_r;
  logic [TW-1:0]    now_r;
  logic [TW-1:0]    now_nxt;
  logic [ENTRIES-1:0] valid_r;

  // slot store
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;
  logic [PW-1:0]    rd_page;
  logic [CW-1:0]    rd_cnt;
  logic [TW-1:0]    rd_stamp;
  logic             rd_is_valid;
  logic             better;

  // commit values
  logic [IDX_W-1:0] commit_slot;
  logic [CW-1:0]    commit_cnt;
  logic             commit_evict;

  assign rd_page     = ram_rdata[RW-1 -: PW];
  assign rd_cnt      = ram_rdata[TW +: CW];
  assign rd_stamp    = ram_rdata[TW-1:0];
  assign rd_is_valid = valid_r[cmp_idx_r];

  assign better = !best_vld_r || (rd_cnt < best_cnt_r) ||
                  ((rd_cnt == best_cnt_r) && (rd_stamp < best_stamp_r));

  assign commit_evict = !hit_r && !free_r;

  always_comb begin
    if (hit_r) begin
      commit_slot = found_r;
    end else if (free_r) begin
      commit_slot = free_idx_r;
    end else begin
      commit_slot = best_idx_r;
    end
  end

  always_comb begin
    if (!hit_r) begin
      commit_cnt = CW'(1);
    end else if (hit_cnt_r == lfu_pkg::CNT_MAX) begin
      commit_cnt = hit_cnt_r;
    end else begin
      commit_cnt = hit_cnt_r + CW'(1);
    end
  end

  assign now_nxt   = (now_r == lfu_pkg::STAMP_MAX) ? now_r : now_r + TW'(1);
  assign ram_we    = cmd.commit;
  assign ram_addr  = cmd.commit ? commit_slot : idx_r;
  assign ram_wdata = {page_r, commit_cnt, now_r};

  lfu_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // scan index and compare stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
  end

  // match, first free and victim search, one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r     <= in_page_id[PW-1:0];
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (rd_is_valid) begin
        if (!hit_r && (rd_page == page_r)) begin
          hit_r     <= 1'b1;
          found_r   <= cmp_idx_r;
          hit_cnt_r <= rd_cnt;
        end
        if (better) begin
          best_vld_r   <= 1'b1;
          best_idx_r   <= cmp_idx_r;
          best_cnt_r   <= rd_cnt;
          best_stamp_r <= rd_stamp;
          best_page_r  <= rd_page;
        end
      end else if (!free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // valid bits and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      now_r   <= '0;
    end else if (cmd.commit) begin
      valid_r[commit_slot] <= 1'b1;
      now_r                <= now_nxt;
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit          <= hit_r;
      out_slot         <= lfu_pkg::SLOT_W'(commit_slot);
      out_evicted      <= commit_evict;
      out_evicted_page <= commit_evict ? lfu_pkg::PAGE_ID_W'(best_page_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.last_issue = (idx_r == last_idx);
  assign stat.out_free   = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  a_commit_not_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("commit over a waiting result");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> valid_r[$past(commit_slot)])
    else $error("committed slot not marked valid");

  a_evict_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && commit_evict) |-> best_vld_r)
    else $error("eviction without a victim");
`endif

endmodule
